@@ sv/fmjr_pkg.sv @@
// Shared types and constants for the feeder motor jam recovery controller.
package fmjr_pkg;

  // Timer width and its saturation value
  localparam int unsigned TimerBits = 16;
  localparam logic [TimerBits-1:0] TimerMax = '1;

  // Configuration register widths, indexes and reset values
  localparam int unsigned LimitBits = 12;
  localparam int unsigned TicksBits = 16;
  localparam int unsigned CfgIdxBits = 1;
  localparam int unsigned CfgDataBits = 16;
  localparam logic [CfgIdxBits-1:0] CfgCurrentLimit = 1'b0;
  localparam logic [CfgIdxBits-1:0] CfgRecoveryTicks = 1'b1;
  localparam logic [LimitBits-1:0] LimitReset = 12'd500;
  localparam logic [TicksBits-1:0] TicksReset = 16'd1000;

  // Stream widths
  localparam int unsigned InDataBits = 16;
  localparam int unsigned OutDataBits = 8;

  // Motor commands
  localparam logic [1:0] CmdFwd = 2'd0;
  localparam logic [1:0] CmdRev = 2'd1;
  localparam logic [1:0] CmdCoast = 2'd2;
  localparam logic [1:0] CmdBrake = 2'd3;

  // Reported phase codes
  localparam logic [2:0] PhCodeIdle = 3'd0;
  localparam logic [2:0] PhCodeWait = 3'd1;
  localparam logic [2:0] PhCodeRun = 3'd2;
  localparam logic [2:0] PhCodeRcoast = 3'd3;
  localparam logic [2:0] PhCodeRpush = 3'd4;

  // Control phases, one-hot
  typedef enum logic [4:0] {
    PhIdle   = 5'b00001,
    PhWait   = 5'b00010,
    PhRun    = 5'b00100,
    PhRcoast = 5'b01000,
    PhRpush  = 5'b10000
  } phase_e;

  // Classified item handed from the front to the back
  typedef struct packed {
    logic       is_cmd;
    logic [1:0] cmd;
    logic       slide_ok;
    logic       front_lim;
    logic       over_limit;
  } op_t;

  // Controller state
  typedef struct packed {
    logic                 motor_en;
    logic [1:0]           active_cmd;
    phase_e               phase;
    logic [TimerBits-1:0] timer;
    logic                 dir;
    logic                 drv;
    logic                 pend_v;
    logic [1:0]           pend_cmd;
  } ctl_state_t;

endpackage

@@ sv/fmjr_front.sv @@
// Front end: holds configuration, accepts items and classifies them.
module fmjr_front (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [fmjr_pkg::CfgIdxBits-1:0]    cfg_idx_i,
  input  logic [fmjr_pkg::CfgDataBits-1:0]   cfg_data_i,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  logic [fmjr_pkg::InDataBits-1:0]    in_data_i,
  input  logic                               in_func_i,
  output logic                               op_valid_o,
  input  logic                               op_ready_i,
  output fmjr_pkg::op_t                      op_o,
  output logic [fmjr_pkg::TicksBits-1:0]     recovery_ticks_o
);

  logic [fmjr_pkg::LimitBits-1:0] limit_q;
  logic [fmjr_pkg::TicksBits-1:0] ticks_q;
  logic                           valid_q, valid_d;
  fmjr_pkg::op_t                  op_q, op_d;
  logic                           in_xfer;
  logic [fmjr_pkg::LimitBits-1:0] cur;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= fmjr_pkg::LimitReset;
      ticks_q <= fmjr_pkg::TicksReset;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        fmjr_pkg::CfgCurrentLimit:  limit_q <= cfg_data_i[fmjr_pkg::LimitBits-1:0];
        fmjr_pkg::CfgRecoveryTicks: ticks_q <= cfg_data_i[fmjr_pkg::TicksBits-1:0];
        default: ;
      endcase
    end
  end

  assign recovery_ticks_o = ticks_q;

  // Stage register: takes a new transfer whenever it is empty or draining
  assign in_ready_o = !valid_q || op_ready_i;
  assign in_xfer    = in_valid_i && in_ready_o;

  // Classify: unpack fields and do the current compare here
  always_comb begin
    cur              = in_data_i[15:4];
    op_d.is_cmd      = in_func_i;
    op_d.cmd         = in_data_i[1:0];
    op_d.slide_ok    = in_data_i[2];
    op_d.front_lim   = in_data_i[3];
    op_d.over_limit  = cur > limit_q;
    valid_d          = in_xfer || (valid_q && !op_ready_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      op_q <= op_d;
    end
  end

  assign op_valid_o = valid_q;
  assign op_o       = op_q;

endmodule

@@ sv/fmjr_queue.sv @@
// Two-entry queue of classified items between front and back.
module fmjr_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_valid_i,
  output logic          push_ready_o,
  input  fmjr_pkg::op_t push_op_i,
  output logic          pop_valid_o,
  input  logic          pop_ready_i,
  output fmjr_pkg::op_t pop_op_o
);

  fmjr_pkg::op_t mem_q [2];
  logic          wr_ptr_q, wr_ptr_d;
  logic          rd_ptr_q, rd_ptr_d;
  logic [1:0]    count_q, count_d;
  logic          push, pop;

  assign push_ready_o = count_q != 2'd2;
  assign pop_valid_o  = count_q != 2'd0;
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;
  assign pop_op_o     = mem_q[rd_ptr_q];

  // Pointer and fill count update
  always_comb begin
    wr_ptr_d = push ? !wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop ? !rd_ptr_q : rd_ptr_q;
    count_d  = count_q;
    if (push && !pop) begin
      count_d = count_q + 2'd1;
    end else if (pop && !push) begin
      count_d = count_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_op_i;
    end
  end

endmodule

@@ sv/fmjr_back.sv @@
// Back end: bridge control state machine with jam recovery and output register.
module fmjr_back (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic [fmjr_pkg::TicksBits-1:0]     recovery_ticks_i,
  input  logic                               op_valid_i,
  output logic                               op_ready_o,
  input  fmjr_pkg::op_t                      op_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic [fmjr_pkg::OutDataBits-1:0]   out_data_o
);

  fmjr_pkg::ctl_state_t            st_q, st_d, w;
  logic                            out_valid_q, out_valid_d;
  logic [fmjr_pkg::OutDataBits-1:0] out_data_q, out_data_d;
  logic                            pop;
  logic                            dropped;
  logic                            done;
  logic [fmjr_pkg::TimerBits-1:0]  lim;
  logic [fmjr_pkg::TimerBits-1:0]  tnext;
  logic [2:0]                      ph_code;
  logic [31:0]                     ticks_ext;
  logic [31:0]                     max_ext;

  // Apply a command to the bridge state
  function automatic fmjr_pkg::ctl_state_t apply_cmd(fmjr_pkg::ctl_state_t s,
                                                      logic [1:0] cmd);
    fmjr_pkg::ctl_state_t r;
    r            = s;
    r.active_cmd = cmd;
    unique case (cmd)
      fmjr_pkg::CmdFwd: begin
        r.phase = fmjr_pkg::PhWait;
      end
      fmjr_pkg::CmdRev: begin
        r.motor_en = 1'b1;
        r.dir      = 1'b0;
        r.drv      = 1'b1;
        r.phase    = fmjr_pkg::PhRun;
      end
      fmjr_pkg::CmdCoast: begin
        r.motor_en = 1'b0;
        r.dir      = 1'b1;
        r.drv      = 1'b0;
        r.phase    = fmjr_pkg::PhIdle;
      end
      default: begin
        r.motor_en = 1'b0;
        r.dir      = 1'b0;
        r.drv      = 1'b0;
        r.phase    = fmjr_pkg::PhIdle;
      end
    endcase
    return r;
  endfunction

  // Phase length, capped at the timer's reach; zero behaves as one
  always_comb begin
    ticks_ext = 32'(recovery_ticks_i);
    max_ext   = 32'(fmjr_pkg::TimerMax);
    if (ticks_ext > max_ext) begin
      lim = fmjr_pkg::TimerMax;
    end else begin
      lim = fmjr_pkg::TimerBits'(ticks_ext);
    end
  end

  assign op_ready_o = !out_valid_q || out_ready_i;
  assign pop        = op_valid_i && op_ready_o;

  // Next state for the item at the queue head
  always_comb begin
    w       = st_q;
    dropped = 1'b0;
    tnext   = (st_q.timer != fmjr_pkg::TimerMax) ? st_q.timer + 1'b1 : st_q.timer;
    done    = tnext >= lim;
    if (op_i.is_cmd) begin
      dropped = st_q.pend_v;
      if (st_q.phase == fmjr_pkg::PhWait || st_q.phase == fmjr_pkg::PhRcoast ||
          st_q.phase == fmjr_pkg::PhRpush) begin
        w.pend_cmd = op_i.cmd;
        w.pend_v   = 1'b1;
      end else begin
        w.pend_v = 1'b0;
        w        = apply_cmd(w, op_i.cmd);
      end
    end else begin
      // Release a pending command first when free
      if (w.pend_v && (w.phase == fmjr_pkg::PhIdle || w.phase == fmjr_pkg::PhRun)) begin
        w.pend_v = 1'b0;
        w        = apply_cmd(w, w.pend_cmd);
      end
      unique case (w.phase)
        fmjr_pkg::PhWait: begin
          if (op_i.slide_ok) begin
            w.motor_en = 1'b1;
            w.dir      = 1'b1;
            w.drv      = 1'b1;
            w.phase    = fmjr_pkg::PhRun;
          end
        end
        fmjr_pkg::PhRun: begin
          if (w.active_cmd == fmjr_pkg::CmdFwd && op_i.front_lim) begin
            w.motor_en = 1'b0;
            w.dir      = 1'b1;
            w.drv      = 1'b0;
            w.phase    = fmjr_pkg::PhIdle;
          end else if (op_i.over_limit) begin
            w.dir   = 1'b1;
            w.drv   = 1'b0;
            w.timer = '0;
            w.phase = fmjr_pkg::PhRcoast;
          end
        end
        fmjr_pkg::PhRcoast: begin
          // A recovery phase is never entered by a pending release, so the timer is st_q's
          if (done) begin
            w.timer = '0;
            w.dir   = (w.active_cmd == fmjr_pkg::CmdFwd);
            w.drv   = 1'b1;
            w.phase = fmjr_pkg::PhRpush;
          end else begin
            w.timer = tnext;
          end
        end
        fmjr_pkg::PhRpush: begin
          if (done) begin
            w.timer = '0;
            w.dir   = (w.active_cmd != fmjr_pkg::CmdFwd);
            w.drv   = 1'b1;
            w.phase = fmjr_pkg::PhRun;
          end else begin
            w.timer = tnext;
          end
        end
        default: ;
      endcase
    end
    st_d = pop ? w : st_q;
  end

  // Phase code for the result
  always_comb begin
    unique case (w.phase)
      fmjr_pkg::PhWait:   ph_code = fmjr_pkg::PhCodeWait;
      fmjr_pkg::PhRun:    ph_code = fmjr_pkg::PhCodeRun;
      fmjr_pkg::PhRcoast: ph_code = fmjr_pkg::PhCodeRcoast;
      fmjr_pkg::PhRpush:  ph_code = fmjr_pkg::PhCodeRpush;
      default:            ph_code = fmjr_pkg::PhCodeIdle;
    endcase
  end

  // Output register
  always_comb begin
    out_data_d  = {1'b0, dropped, ph_code, w.motor_en, w.drv, w.dir};
    out_valid_d = pop || (out_valid_q && !out_ready_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q.motor_en   <= 1'b0;
      st_q.active_cmd <= fmjr_pkg::CmdBrake;
      st_q.phase      <= fmjr_pkg::PhIdle;
      st_q.timer      <= '0;
      st_q.dir        <= 1'b0;
      st_q.drv        <= 1'b0;
      st_q.pend_v     <= 1'b0;
      st_q.pend_cmd   <= fmjr_pkg::CmdFwd;
      out_valid_q     <= 1'b0;
    end else begin
      st_q        <= st_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop) begin
      out_data_q <= out_data_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

@@ sv/feed_motor_jam_recovery_controller_unit.sv @@
// Top level of the feeder motor jam recovery controller.
// A result passes through the front stage, the queue and the output register.
// Throughput: one item per cycle while the output is not stalled.
// Stalls on the output side are absorbed by the two-entry queue and the front stage.
// Reset (rst_ni low, asynchronous): motor off, brake pins, idle, queue empty,
// current_limit 500, recovery_ticks 1000.
module feed_motor_jam_recovery_controller_unit (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [fmjr_pkg::CfgIdxBits-1:0]    cfg_idx_i,
  input  logic [fmjr_pkg::CfgDataBits-1:0]   cfg_data_i,
  input  logic                               s_axis_tvalid_i,
  output logic                               s_axis_tready_o,
  // [1:0] command, [2] slide_back_ok, [3] front_limit, [15:4] load_current
  input  logic [fmjr_pkg::InDataBits-1:0]    s_axis_tdata_i,
  // [0] func
  input  logic                               s_axis_tuser_i,
  output logic                               m_axis_tvalid_o,
  input  logic                               m_axis_tready_i,
  // [0] dir_pin, [1] drive_pin, [2] running, [5:3] phase, [6] command_dropped, [7] zero
  output logic [fmjr_pkg::OutDataBits-1:0]   m_axis_tdata_o
);

  logic                           f_valid, f_ready;
  fmjr_pkg::op_t                  f_op;
  logic                           q_valid, q_ready;
  fmjr_pkg::op_t                  q_op;
  logic [fmjr_pkg::TicksBits-1:0] ticks;

  fmjr_front u_front (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_idx_i        (cfg_idx_i),
    .cfg_data_i       (cfg_data_i),
    .in_valid_i       (s_axis_tvalid_i),
    .in_ready_o       (s_axis_tready_o),
    .in_data_i        (s_axis_tdata_i),
    .in_func_i        (s_axis_tuser_i),
    .op_valid_o       (f_valid),
    .op_ready_i       (f_ready),
    .op_o             (f_op),
    .recovery_ticks_o (ticks)
  );

  fmjr_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (f_valid),
    .push_ready_o (f_ready),
    .push_op_i    (f_op),
    .pop_valid_o  (q_valid),
    .pop_ready_i  (q_ready),
    .pop_op_o     (q_op)
  );

  fmjr_back u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .recovery_ticks_i (ticks),
    .op_valid_i       (q_valid),
    .op_ready_o       (q_ready),
    .op_i             (q_op),
    .out_valid_o      (m_axis_tvalid_o),
    .out_ready_i      (m_axis_tready_i),
    .out_data_o       (m_axis_tdata_o)
  );

endmodule

@@ test/testbench.sv @@
// Self-checking testbench for the feeder motor jam recovery controller.
`timescale 1ns / 1ps

module testbench;

  // One input item, fields as the stream carries them
  typedef struct packed {
    logic        func;
    logic [1:0]  cmd;
    logic        slide;
    logic        front;
    logic [11:0] load;
  } feed_item_t;

  // One result, laid out like m_axis_tdata_o[6:0]
  typedef struct packed {
    logic       command_dropped;
    logic [2:0] phase;
    logic       running;
    logic       drive_pin;
    logic       dir_pin;
  } motor_out_t;

  // Directed step: item, whether a hand-written result applies, and that result
  typedef struct packed {
    feed_item_t item;
    logic       fixed;
    motor_out_t want;
  } script_row_t;

  localparam int ScriptLen = 23;
  localparam int NumSettings = 8;
  localparam int DrainCycles = 6;

  logic                             clk_i = 1'b0;
  logic                             rst_ni = 1'b0;
  logic                             cfg_we_i = 1'b0;
  logic [fmjr_pkg::CfgIdxBits-1:0]  cfg_idx_i = '0;
  logic [fmjr_pkg::CfgDataBits-1:0] cfg_data_i = '0;
  logic                             s_axis_tvalid_i = 1'b0;
  logic                             s_axis_tready_o;
  logic [fmjr_pkg::InDataBits-1:0]  s_axis_tdata_i = '0;
  logic                             s_axis_tuser_i = 1'b0;
  logic                             m_axis_tvalid_o;
  logic                             m_axis_tready_i = 1'b0;
  logic [fmjr_pkg::OutDataBits-1:0] m_axis_tdata_o;

  feed_motor_jam_recovery_controller_unit u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_data_i      (cfg_data_i),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    // [1:0] command, [2] slide_back_ok, [3] front_limit, [15:4] load_current
    .s_axis_tdata_i  (s_axis_tdata_i),
    // [0] func
    .s_axis_tuser_i  (s_axis_tuser_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    // [0] dir_pin, [1] drive_pin, [2] running, [5:3] phase, [6] command_dropped, [7] zero
    .m_axis_tdata_o  (m_axis_tdata_o)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Bridge state as the controller should hold it
  logic        motor_on;
  logic [1:0]  live_cmd;
  logic [2:0]  ctl_phase;
  logic [15:0] recov_count;
  logic        dir_level;
  logic        drv_level;
  logic        held_valid;
  logic [1:0]  held_cmd;
  logic [11:0] limit_setting;
  logic [15:0] ticks_setting;

  motor_out_t pin_results_q[$];
  int err_cnt = 0;
  int burst_left = 0;
  int n_ticks = 0;
  int n_cmds = 0;
  int n_dropped = 0;
  int n_recoveries = 0;

  script_row_t script [ScriptLen] = '{
    '{'{1'b1, fmjr_pkg::CmdBrake, 1'b0, 1'b0, 12'd0},    1'b1,
      '{1'b0, fmjr_pkg::PhCodeIdle, 1'b0, 1'b0, 1'b0}},
    '{'{1'b0, fmjr_pkg::CmdFwd,   1'b1, 1'b1, 12'd4095}, 1'b1,
      '{1'b0, fmjr_pkg::PhCodeIdle, 1'b0, 1'b0, 1'b0}},
    '{'{1'b1, fmjr_pkg::CmdCoast, 1'b0, 1'b0, 12'd0},    1'b1,
      '{1'b0, fmjr_pkg::PhCodeIdle, 1'b0, 1'b0, 1'b1}},
    '{'{1'b1, fmjr_pkg::CmdFwd,   1'b0, 1'b0, 12'd0},    1'b0, '0},
    '{'{1'b0, fmjr_pkg::CmdRev,   1'b1, 1'b0, 12'd4095}, 1'b0, '0},
    '{'{1'b0, fmjr_pkg::CmdBrake, 1'b0, 1'b1, 12'd4095}, 1'b0, '0},
    '{'{1'b1, fmjr_pkg::CmdFwd,   1'b1, 1'b1, 12'd4095}, 1'b0, '0},
    '{'{1'b0, fmjr_pkg::CmdFwd,   1'b0, 1'b1, 12'd4095}, 1'b0, '0},
    '{'{1'b1, fmjr_pkg::CmdRev,   1'b0, 1'b0, 12'd0},    1'b0, '0},
    '{'{1'b1, fmjr_pkg::CmdBrake, 1'b0, 1'b0, 12'd0},    1'b1,
      '{1'b1, fmjr_pkg::PhCodeWait, 1'b0, 1'b0, 1'b1}},
    '{'{1'b0, fmjr_pkg::CmdFwd,   1'b1, 1'b0, 12'd0},    1'b0, '0},
    '{'{1'b1, fmjr_pkg::CmdCoast, 1'b0, 1'b0, 12'd0},    1'b1,
      '{1'b1, fmjr_pkg::PhCodeIdle, 1'b0, 1'b0, 1'b1}},
    '{'{1'b1, fmjr_pkg::CmdFwd,   1'b0, 1'b0, 12'd0},    1'b0, '0},
    '{'{1'b1, fmjr_pkg::CmdRev,   1'b0, 1'b0, 12'd0},    1'b0, '0},
    '{'{1'b0, fmjr_pkg::CmdFwd,   1'b1, 1'b0, 12'd4095}, 1'b0, '0},
    '{'{1'b0, fmjr_pkg::CmdFwd,   1'b0, 1'b0, 12'd0},    1'b0, '0},
    '{'{1'b0, fmjr_pkg::CmdFwd,   1'b0, 1'b1, 12'd500},  1'b0, '0},
    '{'{1'b0, fmjr_pkg::CmdFwd,   1'b0, 1'b0, 12'd501},  1'b0, '0},
    '{'{1'b0, fmjr_pkg::CmdFwd,   1'b0, 1'b0, 12'd0},    1'b0, '0},
    '{'{1'b1, fmjr_pkg::CmdFwd,   1'b0, 1'b0, 12'd0},    1'b0, '0},
    '{'{1'b1, fmjr_pkg::CmdCoast, 1'b0, 1'b0, 12'd0},    1'b0, '0},
    '{'{1'b0, fmjr_pkg::CmdFwd,   1'b1, 1'b1, 12'd4095}, 1'b0, '0},
    '{'{1'b1, fmjr_pkg::CmdBrake, 1'b0, 1'b0, 12'd0},    1'b0, '0}
  };

  // Settings for the random part; a tick count of zero behaves as one
  int unsigned limit_plan [NumSettings] = '{0, 4095, 700, 1500, 300, 2048, 100, 4000};
  int unsigned ticks_plan [NumSettings] = '{1, 3, 0, 65535, 5, 2, 16, 1};
  int unsigned count_plan [NumSettings] = '{250, 200, 200, 80, 300, 300, 250, 170};

  // Put the bridge into the state a command selects
  function automatic void take_command(input logic [1:0] c);
    live_cmd = c;
    case (c)
      fmjr_pkg::CmdFwd: begin
        ctl_phase = fmjr_pkg::PhCodeWait;
      end
      fmjr_pkg::CmdRev: begin
        motor_on = 1'b1;
        dir_level = 1'b0;
        drv_level = 1'b1;
        ctl_phase = fmjr_pkg::PhCodeRun;
      end
      fmjr_pkg::CmdCoast: begin
        motor_on = 1'b0;
        dir_level = 1'b1;
        drv_level = 1'b0;
        ctl_phase = fmjr_pkg::PhCodeIdle;
      end
      default: begin
        motor_on = 1'b0;
        dir_level = 1'b0;
        drv_level = 1'b0;
        ctl_phase = fmjr_pkg::PhCodeIdle;
      end
    endcase
  endfunction

  // Count one recovery tick; true once the phase length is reached
  function automatic logic recovery_elapsed();
    if (recov_count < fmjr_pkg::TimerMax) recov_count = recov_count + 16'd1;
    return recov_count >= ticks_setting;
  endfunction

  // Sensor tick: release a held command, then advance the phase
  function automatic void advance_tick(input feed_item_t it);
    if (held_valid &&
        (ctl_phase == fmjr_pkg::PhCodeIdle || ctl_phase == fmjr_pkg::PhCodeRun)) begin
      held_valid = 1'b0;
      take_command(held_cmd);
    end
    case (ctl_phase)
      fmjr_pkg::PhCodeWait: begin
        if (it.slide) begin
          motor_on = 1'b1;
          dir_level = 1'b1;
          drv_level = 1'b1;
          ctl_phase = fmjr_pkg::PhCodeRun;
        end
      end
      fmjr_pkg::PhCodeRun: begin
        // front limit wins over the current check
        if (live_cmd == fmjr_pkg::CmdFwd && it.front) begin
          motor_on = 1'b0;
          dir_level = 1'b1;
          drv_level = 1'b0;
          ctl_phase = fmjr_pkg::PhCodeIdle;
        end else if (it.load > limit_setting) begin
          dir_level = 1'b1;
          drv_level = 1'b0;
          recov_count = '0;
          ctl_phase = fmjr_pkg::PhCodeRcoast;
          n_recoveries++;
        end
      end
      fmjr_pkg::PhCodeRcoast: begin
        if (recovery_elapsed()) begin
          recov_count = '0;
          dir_level = (live_cmd == fmjr_pkg::CmdFwd);
          drv_level = 1'b1;
          ctl_phase = fmjr_pkg::PhCodeRpush;
        end
      end
      fmjr_pkg::PhCodeRpush: begin
        if (recovery_elapsed()) begin
          recov_count = '0;
          dir_level = (live_cmd != fmjr_pkg::CmdFwd);
          drv_level = 1'b1;
          ctl_phase = fmjr_pkg::PhCodeRun;
        end
      end
      default: ;
    endcase
  endfunction

  // Expected pins and flags after one accepted item
  function automatic motor_out_t bridge_predict(input feed_item_t it);
    motor_out_t res;
    logic dropped;
    dropped = 1'b0;
    if (it.func) begin
      dropped = held_valid;
      if (ctl_phase == fmjr_pkg::PhCodeWait || ctl_phase == fmjr_pkg::PhCodeRcoast ||
          ctl_phase == fmjr_pkg::PhCodeRpush) begin
        held_cmd = it.cmd;
        held_valid = 1'b1;
      end else begin
        held_valid = 1'b0;
        take_command(it.cmd);
      end
    end else begin
      advance_tick(it);
    end
    res.dir_pin = dir_level;
    res.drive_pin = drv_level;
    res.running = motor_on;
    res.phase = ctl_phase;
    res.command_dropped = dropped;
    return res;
  endfunction

  // Random item, mostly ticks, with load samples clustered around the limit
  function automatic feed_item_t pick_item();
    feed_item_t it;
    int level;
    it.func = ($urandom_range(0, 99) < 22);
    it.cmd = ($urandom_range(0, 9) < 4) ? fmjr_pkg::CmdFwd : 2'($urandom_range(0, 3));
    it.slide = 1'($urandom_range(0, 1));
    it.front = ($urandom_range(0, 7) == 0);
    case ($urandom_range(0, 9))
      0, 1, 2, 3: level = $urandom_range(0, 4095);
      4, 5, 6:    level = int'(limit_setting) + $urandom_range(0, 4) - 2;
      default:    level = $urandom_range(0, limit_setting);
    endcase
    if (level < 0) level = 0;
    if (level > 4095) level = 4095;
    it.load = 12'(level);
    return it;
  endfunction

  // Offer one item in the sender's burst pattern and wait for its transfer
  task automatic offer_item(input feed_item_t it);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 6);
      if (gap > 0) begin
        s_axis_tvalid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = ($urandom_range(0, 5) == 0) ? 150 : $urandom_range(1, 16);
    end
    burst_left--;
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i <= {it.load, it.front, it.slide, it.cmd};
    s_axis_tuser_i <= it.func;
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
    if (it.func) n_cmds++;
    else n_ticks++;
  endtask

  // Stop offering and let every outstanding result come back
  task automatic drain_results();
    s_axis_tvalid_i <= 1'b0;
    while (pin_results_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  // Write both registers on consecutive edges while the block is idle
  task automatic write_settings(input logic [11:0] limit, input logic [15:0] ticks);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= fmjr_pkg::CfgCurrentLimit;
    cfg_data_i <= {4'd0, limit};
    @(posedge clk_i);
    cfg_idx_i <= fmjr_pkg::CfgRecoveryTicks;
    cfg_data_i <= ticks;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    limit_setting = limit;
    ticks_setting = ticks;
  endtask

  // Receiver: pattern of ready modes, plus one long hold-off
  int rx_cycle;
  int rx_mode;
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready_i <= 1'b0;
      rx_cycle <= 0;
      rx_mode <= 0;
    end else begin
      rx_cycle <= rx_cycle + 1;
      if (rx_cycle % 64 == 0) rx_mode <= $urandom_range(0, 3);
      if (rx_cycle >= 400 && rx_cycle < 700) begin
        m_axis_tready_i <= 1'b0;
      end else begin
        case (rx_mode)
          0:       m_axis_tready_i <= 1'b1;
          1:       m_axis_tready_i <= 1'($urandom_range(0, 1));
          2:       m_axis_tready_i <= ($urandom_range(0, 3) == 0);
          default: m_axis_tready_i <= (rx_cycle % 8 != 0);
        endcase
      end
    end
  end

  // Compare each result transfer with the oldest expectation
  always @(posedge clk_i) begin : result_check
    motor_out_t got;
    motor_out_t want;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      got = m_axis_tdata_o[6:0];
      if (pin_results_q.size() == 0) begin
        $error("result transfer with nothing expected: %h", m_axis_tdata_o);
        err_cnt++;
      end else begin
        want = pin_results_q.pop_front();
        if (got.command_dropped) n_dropped++;
        if (got.dir_pin !== want.dir_pin) begin
          $error("dir_pin: expected %0d, got %0d", want.dir_pin, got.dir_pin);
          err_cnt++;
        end
        if (got.drive_pin !== want.drive_pin) begin
          $error("drive_pin: expected %0d, got %0d", want.drive_pin, got.drive_pin);
          err_cnt++;
        end
        if (got.running !== want.running) begin
          $error("running: expected %0d, got %0d", want.running, got.running);
          err_cnt++;
        end
        if (got.phase !== want.phase) begin
          $error("phase: expected %0d, got %0d", want.phase, got.phase);
          err_cnt++;
        end
        if (got.command_dropped !== want.command_dropped) begin
          $error("command_dropped: expected %0d, got %0d",
                 want.command_dropped, got.command_dropped);
          err_cnt++;
        end
      end
    end
  end

  // Stimulus: directed script under reset settings, then random phases
  initial begin : stimulus
    feed_item_t it;
    motor_out_t want;
    motor_on = 1'b0;
    live_cmd = fmjr_pkg::CmdBrake;
    ctl_phase = fmjr_pkg::PhCodeIdle;
    recov_count = '0;
    dir_level = 1'b0;
    drv_level = 1'b0;
    held_valid = 1'b0;
    held_cmd = fmjr_pkg::CmdFwd;
    limit_setting = fmjr_pkg::LimitReset;
    ticks_setting = fmjr_pkg::TicksReset;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int i = 0; i < ScriptLen; i++) begin
      offer_item(script[i].item);
      want = bridge_predict(script[i].item);
      pin_results_q.push_back(script[i].fixed ? script[i].want : want);
    end

    for (int p = 0; p < NumSettings; p++) begin
      drain_results();
      write_settings(12'(limit_plan[p]), 16'(ticks_plan[p]));
      for (int n = 0; n < int'(count_plan[p]); n++) begin
        it = pick_item();
        offer_item(it);
        pin_results_q.push_back(bridge_predict(it));
      end
    end

    drain_results();
    $display("Covered %0d ticks and %0d commands over %0d register settings;",
             n_ticks, n_cmds, NumSettings + 1);
    $display("%0d jam recoveries entered, %0d command drops seen.",
             n_recoveries, n_dropped);
    if (err_cnt == 0) begin
      $display("PASS feed_motor_jam_recovery_controller_unit");
    end else begin
      $display("FAIL feed_motor_jam_recovery_controller_unit");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #2_000_000;
    $display("FAIL feed_motor_jam_recovery_controller_unit");
    $finish;
  end

endmodule
